[design/sdp_attribute_extractor_macros.svh]
// Assertion macros shared by the session description extractor RTL
`ifndef SDP_ATTRIBUTE_EXTRACTOR_MACROS_SVH
`define SDP_ATTRIBUTE_EXTRACTOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SDPAE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next clock cycle.
`define SDPAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sdpae_pkg.sv]
// Types, codes and name tables for the session description extractor
package sdpae_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_FIRST  = 3'd1,
        PH_NAME   = 3'd2,
        PH_SKIPWS = 3'd3,
        PH_VALUE  = 3'd4,
        PH_IGNORE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CONN  = 2'd1,
        KIND_ATTR  = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    localparam logic [2:0] FID_CONN        = 3'd0;
    localparam logic [2:0] FID_MIN_LATENCY = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_A     = 8'h61;

    localparam int NAME_COUNT = 5;
    localparam int NAME_MAX   = 11;

    localparam logic [4:0] CAND_ALL = 5'h1F;
    localparam logic [3:0] POS_MAX  = 4'd15;

    // Names are stored right-aligned: the first character sits in the highest used byte.
    localparam logic [NAME_MAX*8-1:0] NAME_TEXT [NAME_COUNT] = '{
        "rtpmap", "fmtp", "fpaeskey", "aesiv", "min-latency"
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{4'd6, 4'd4, 4'd8, 4'd5, 4'd11};

    typedef struct packed {
        logic [4:0] cand;      // candidates left after this character
        logic [3:0] pos;       // saturating name position
        logic [2:0] close_id;  // field id if the name ends here, else 0
    } match_t;

    // Character pos of name idx; caller guarantees pos < length.
    function automatic logic [7:0] name_char(input int idx, input logic [3:0] pos);
        logic [3:0] off;
        logic [NAME_MAX*8-1:0] text;
        text = NAME_TEXT[idx];
        off  = 4'(NAME_LEN[idx] - pos - 4'd1);
        return text[{off, 3'b000} +: 8];
    endfunction

endpackage

[design/sdpae_name_match.sv]
// Parallel attribute name matcher: narrows candidates and resolves the name at ':'
module sdpae_name_match
(
    input  logic [4:0]      cand,
    input  logic [3:0]      pos,
    input  logic [7:0]      data,
    output sdpae_pkg::match_t match
);

    always_comb
    begin
        match.cand     = '0;
        match.close_id = '0;
        for (int i = 0; i < sdpae_pkg::NAME_COUNT; i++)
        begin
            // keep a candidate only while the character agrees
            if (cand[i] && (pos < sdpae_pkg::NAME_LEN[i])
                && (sdpae_pkg::name_char(i, pos) == data))
            begin
                match.cand[i] = 1'b1;
            end
            // a complete candidate at ':' names the field
            if (cand[i] && (pos == sdpae_pkg::NAME_LEN[i]))
            begin
                match.close_id = 3'(i + 1);
            end
        end
        match.pos = (pos == sdpae_pkg::POS_MAX) ? pos : pos + 4'd1;
    end

endmodule

[design/sdp_attribute_extractor.sv]
// Top level: streaming session description extractor (c= and selected a= values)
// An accepted byte is held in the input register; its result is loaded into the result register.
// Throughput: one byte per cycle while the master side takes results; the per-byte parse is one
// pass through a parallel name compare between the input register and the result register.
// Reset: rst_n low clears both valid flags and returns the parser to line start with no
// fields found; the last byte of each message restores the same state.
module sdp_attribute_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [8] has_byte, [9] value_end,
                                        // [15:10] found_mask
    output logic [2:0]  m_axis_tuser,   // [2:0] field_id
    output logic        m_axis_tlast    // message_end
);

`include "sdp_attribute_extractor_macros.svh"

    // Input register: one byte waiting to be parsed
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parser state
    sdpae_pkg::phase_t line_phase_reg, line_phase_next, phase_proc;
    sdpae_pkg::kind_t  line_kind_reg, line_kind_next, kind_proc;
    logic [3:0] name_pos_reg, name_pos_next, pos_proc;
    logic [4:0] cand_reg, cand_next, cand_proc;
    logic [2:0] active_reg, active_next, active_proc;
    logic [5:0] found_reg, found_next, found_proc;
    logic       stopped_reg, stopped_next, stopped_proc;

    // Result register
    logic       out_valid_reg;
    logic [2:0] out_fid_reg;
    logic [7:0] out_vbyte_reg;
    logic       out_hb_reg;
    logic       out_ve_reg;
    logic       out_me_reg;
    logic [5:0] out_mask_reg;

    // Result of the current byte
    logic       emit;
    logic [2:0] res_fid;
    logic [7:0] res_vbyte;
    logic       res_hb;
    logic       res_ve;
    logic       res_me;
    logic [5:0] res_mask;

    logic advance;
    logic term;
    logic is_ws;
    sdpae_pkg::match_t match;

    sdpae_name_match u_match
    (
        .cand  (cand_reg),
        .pos   (name_pos_reg),
        .data  (in_byte_reg),
        .match (match)
    );

    assign term  = (in_byte_reg == sdpae_pkg::CH_NUL) || (in_byte_reg == sdpae_pkg::CH_CR)
                   || (in_byte_reg == sdpae_pkg::CH_LF);
    assign is_ws = (in_byte_reg == sdpae_pkg::CH_SPACE) || (in_byte_reg == sdpae_pkg::CH_TAB);

    // Parse the held byte when the result register can take its result (or none is made)
    assign advance       = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Next state: line parse for the held byte
    always_comb
    begin
        phase_proc   = line_phase_reg;
        kind_proc    = line_kind_reg;
        pos_proc     = name_pos_reg;
        cand_proc    = cand_reg;
        active_proc  = active_reg;
        found_proc   = found_reg;
        stopped_proc = stopped_reg;
        if (!stopped_reg)
        begin
            if (term)
            begin
                // end the line; a zero byte freezes parsing until the last byte
                phase_proc = sdpae_pkg::PH_START;
                kind_proc  = sdpae_pkg::KIND_NONE;
                if (in_byte_reg == sdpae_pkg::CH_NUL)
                begin
                    stopped_proc = 1'b1;
                end
            end
            else
            begin
                unique case (line_phase_reg)
                    sdpae_pkg::PH_START:
                    begin
                        if (in_byte_reg == sdpae_pkg::CH_C)
                        begin
                            kind_proc = sdpae_pkg::KIND_CONN;
                        end
                        else if (in_byte_reg == sdpae_pkg::CH_A)
                        begin
                            kind_proc = sdpae_pkg::KIND_ATTR;
                        end
                        else
                        begin
                            kind_proc = sdpae_pkg::KIND_OTHER;
                        end
                        phase_proc = sdpae_pkg::PH_FIRST;
                    end
                    sdpae_pkg::PH_FIRST:
                    begin
                        phase_proc = sdpae_pkg::PH_IGNORE;
                        if (in_byte_reg == sdpae_pkg::CH_EQUAL)
                        begin
                            if (line_kind_reg == sdpae_pkg::KIND_CONN)
                            begin
                                // only the first connection line counts
                                if (!found_reg[sdpae_pkg::FID_CONN])
                                begin
                                    found_proc[sdpae_pkg::FID_CONN] = 1'b1;
                                    active_proc = sdpae_pkg::FID_CONN;
                                    phase_proc  = sdpae_pkg::PH_VALUE;
                                end
                            end
                            else if (line_kind_reg == sdpae_pkg::KIND_ATTR)
                            begin
                                phase_proc = sdpae_pkg::PH_NAME;
                                pos_proc   = '0;
                                cand_proc  = sdpae_pkg::CAND_ALL;
                            end
                        end
                    end
                    sdpae_pkg::PH_NAME:
                    begin
                        if (in_byte_reg == sdpae_pkg::CH_COLON)
                        begin
                            if ((match.close_id != '0) && !found_reg[match.close_id])
                            begin
                                found_proc[match.close_id] = 1'b1;
                                active_proc = match.close_id;
                                phase_proc  = sdpae_pkg::PH_SKIPWS;
                            end
                            else
                            begin
                                phase_proc = sdpae_pkg::PH_IGNORE;
                            end
                        end
                        else
                        begin
                            cand_proc = match.cand;
                            pos_proc  = match.pos;
                        end
                    end
                    sdpae_pkg::PH_SKIPWS, sdpae_pkg::PH_VALUE:
                    begin
                        if (!((line_phase_reg == sdpae_pkg::PH_SKIPWS) && is_ws))
                        begin
                            phase_proc = sdpae_pkg::PH_VALUE;
                        end
                    end
                    default:
                    begin
                        phase_proc = line_phase_reg;
                    end
                endcase
            end
        end

        // the last byte returns everything to the reset state
        if (in_last_reg)
        begin
            line_phase_next = sdpae_pkg::PH_START;
            line_kind_next  = sdpae_pkg::KIND_NONE;
            name_pos_next   = '0;
            cand_next       = sdpae_pkg::CAND_ALL;
            active_next     = '0;
            found_next      = '0;
            stopped_next    = 1'b0;
        end
        else
        begin
            line_phase_next = phase_proc;
            line_kind_next  = kind_proc;
            name_pos_next   = pos_proc;
            cand_next       = cand_proc;
            active_next     = active_proc;
            found_next      = found_proc;
            stopped_next    = stopped_proc;
        end
    end

    // Outputs: the result transaction made by the held byte, if any
    always_comb
    begin
        emit      = 1'b0;
        res_fid   = '0;
        res_vbyte = '0;
        res_hb    = 1'b0;
        res_ve    = 1'b0;
        res_me    = 1'b0;
        res_mask  = '0;
        if (!stopped_reg)
        begin
            if (term)
            begin
                // close an open value at the line end
                if ((line_phase_reg == sdpae_pkg::PH_VALUE)
                    || (line_phase_reg == sdpae_pkg::PH_SKIPWS))
                begin
                    emit    = 1'b1;
                    res_ve  = 1'b1;
                    res_fid = active_reg;
                end
            end
            else if (((line_phase_reg == sdpae_pkg::PH_SKIPWS) && !is_ws)
                     || (line_phase_reg == sdpae_pkg::PH_VALUE))
            begin
                emit      = 1'b1;
                res_hb    = 1'b1;
                res_vbyte = in_byte_reg;
                res_fid   = active_reg;
            end
        end
        if (in_last_reg)
        begin
            // the last byte closes any value still open and reports the found mask
            if ((phase_proc == sdpae_pkg::PH_VALUE) || (phase_proc == sdpae_pkg::PH_SKIPWS))
            begin
                res_ve  = 1'b1;
                res_fid = active_proc;
            end
            emit     = 1'b1;
            res_me   = 1'b1;
            res_mask = found_proc;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Parser state advances once per parsed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_phase_reg <= sdpae_pkg::PH_START;
            line_kind_reg  <= sdpae_pkg::KIND_NONE;
            name_pos_reg   <= '0;
            cand_reg       <= sdpae_pkg::CAND_ALL;
            active_reg     <= '0;
            found_reg      <= '0;
            stopped_reg    <= 1'b0;
        end
        else if (advance)
        begin
            line_phase_reg <= line_phase_next;
            line_kind_reg  <= line_kind_next;
            name_pos_reg   <= name_pos_next;
            cand_reg       <= cand_next;
            active_reg     <= active_next;
            found_reg      <= found_next;
            stopped_reg    <= stopped_next;
        end
    end

    // Result register: load a new transaction, or drop the one just taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_fid_reg   <= res_fid;
            out_vbyte_reg <= res_vbyte;
            out_hb_reg    <= res_hb;
            out_ve_reg    <= res_ve;
            out_me_reg    <= res_me;
            out_mask_reg  <= res_mask;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mask_reg, out_ve_reg, out_hb_reg, out_vbyte_reg};
    assign m_axis_tuser  = out_fid_reg;
    assign m_axis_tlast  = out_me_reg;

    // An open value always belongs to a field already marked found
    `SDPAE_ASSERT(a_open_value_found,
        !((line_phase_reg == sdpae_pkg::PH_VALUE) || (line_phase_reg == sdpae_pkg::PH_SKIPWS))
        || (((found_reg >> active_reg) & 6'd1) != 6'd0),
        "open value for a field not marked found")

    `SDPAE_ASSERT(a_active_range, active_reg <= sdpae_pkg::FID_MIN_LATENCY,
        "active field id out of range")

    `SDPAE_ASSERT(a_stopped_idle, !stopped_reg || (line_phase_reg == sdpae_pkg::PH_START),
        "parser stopped in the middle of a line")

    `SDPAE_ASSERT_NEXT(a_last_clears, advance && in_last_reg,
        (line_phase_reg == sdpae_pkg::PH_START) && (found_reg == '0) && !stopped_reg,
        "state not cleared after the last byte")

endmodule

[bench/tb_sdp_attribute_extractor.sv]
// Self-checking stream testbench for the session description attribute extractor
module tb_sdp_attribute_extractor;

    timeunit 1ns;
    timeprecision 1ps;

    // One result transaction of the extractor, field by field.
    typedef struct packed {
        logic [2:0] fid;
        logic [7:0] vbyte;
        logic       has_byte;
        logic       value_end;
        logic       msg_end;
        logic [5:0] mask;
    } field_event_t;

    // One input byte waiting to go out on the slave side.
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       drain;   // hold this byte until every expected result has come
    } text_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    sdp_attribute_extractor dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser prediction: our own copy of the line/name state.
    // ------------------------------------------------------------------
    string attr_names [sdpae_pkg::NAME_COUNT] =
        '{"rtpmap", "fmtp", "fpaeskey", "aesiv", "min-latency"};

    sdpae_pkg::phase_t ln_phase;
    sdpae_pkg::kind_t  ln_kind;
    logic [3:0] npos;
    logic [4:0] cand;
    logic [2:0] active;
    logic [5:0] found;
    logic       stopped;

    function automatic void clear_parser();
        ln_phase = sdpae_pkg::PH_START;
        ln_kind  = sdpae_pkg::KIND_NONE;
        npos     = 4'd0;
        cand     = sdpae_pkg::CAND_ALL;
        active   = sdpae_pkg::FID_CONN;
        found    = 6'd0;
        stopped  = 1'b0;
    endfunction

    // Advance the parser by one byte; return the result transaction it causes, if any.
    function automatic void parse_byte(input logic [7:0] b, input logic is_last,
                                       output logic emit, output field_event_t ev);
        logic term;
        int   id;
        emit = 1'b0;
        ev   = '0;
        if (!stopped)
        begin
            term = (b == sdpae_pkg::CH_NUL) || (b == sdpae_pkg::CH_CR)
                   || (b == sdpae_pkg::CH_LF);
            if (term)
            begin
                // A terminator closes any open value, even an empty one.
                if (ln_phase == sdpae_pkg::PH_VALUE || ln_phase == sdpae_pkg::PH_SKIPWS)
                begin
                    ev.value_end = 1'b1;
                    ev.fid       = active;
                    emit         = 1'b1;
                end
                ln_phase = sdpae_pkg::PH_START;
                ln_kind  = sdpae_pkg::KIND_NONE;
                if (b == sdpae_pkg::CH_NUL)
                    stopped = 1'b1;
            end
            else
            begin
                case (ln_phase)
                    sdpae_pkg::PH_START:
                    begin
                        if (b == sdpae_pkg::CH_C)
                            ln_kind = sdpae_pkg::KIND_CONN;
                        else if (b == sdpae_pkg::CH_A)
                            ln_kind = sdpae_pkg::KIND_ATTR;
                        else
                            ln_kind = sdpae_pkg::KIND_OTHER;
                        ln_phase = sdpae_pkg::PH_FIRST;
                    end
                    sdpae_pkg::PH_FIRST:
                    begin
                        ln_phase = sdpae_pkg::PH_IGNORE;
                        if (b == sdpae_pkg::CH_EQUAL)
                        begin
                            if (ln_kind == sdpae_pkg::KIND_CONN
                                && !found[sdpae_pkg::FID_CONN])
                            begin
                                found[sdpae_pkg::FID_CONN] = 1'b1;
                                active   = sdpae_pkg::FID_CONN;
                                ln_phase = sdpae_pkg::PH_VALUE;
                            end
                            else if (ln_kind == sdpae_pkg::KIND_ATTR)
                            begin
                                ln_phase = sdpae_pkg::PH_NAME;
                                npos     = 4'd0;
                                cand     = sdpae_pkg::CAND_ALL;
                            end
                        end
                    end
                    sdpae_pkg::PH_NAME:
                    begin
                        if (b == sdpae_pkg::CH_COLON)
                        begin
                            // The name must match in full; first occurrence only.
                            id = 0;
                            for (int i = 0; i < sdpae_pkg::NAME_COUNT; i++)
                                if (cand[i] && npos == attr_names[i].len())
                                    id = i + 1;
                            if (id != 0 && !found[id])
                            begin
                                found[id] = 1'b1;
                                active    = 3'(id);
                                ln_phase  = sdpae_pkg::PH_SKIPWS;
                            end
                            else
                                ln_phase = sdpae_pkg::PH_IGNORE;
                        end
                        else
                        begin
                            for (int i = 0; i < sdpae_pkg::NAME_COUNT; i++)
                                if (cand[i] && !(npos < attr_names[i].len() &&
                                                 attr_names[i][npos] == b))
                                    cand[i] = 1'b0;
                            if (npos < sdpae_pkg::POS_MAX)
                                npos = npos + 4'd1;
                        end
                    end
                    sdpae_pkg::PH_SKIPWS, sdpae_pkg::PH_VALUE:
                    begin
                        if (!(ln_phase == sdpae_pkg::PH_SKIPWS &&
                              (b == sdpae_pkg::CH_SPACE || b == sdpae_pkg::CH_TAB)))
                        begin
                            ln_phase    = sdpae_pkg::PH_VALUE;
                            ev.has_byte = 1'b1;
                            ev.vbyte    = b;
                            ev.fid      = active;
                            emit        = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (is_last)
        begin
            // The last byte may carry a value byte, the value end and the message end at once.
            if (ln_phase == sdpae_pkg::PH_VALUE || ln_phase == sdpae_pkg::PH_SKIPWS)
            begin
                ev.value_end = 1'b1;
                ev.fid       = active;
            end
            ev.msg_end = 1'b1;
            ev.mask    = found;
            emit       = 1'b1;
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: session description messages built line by line.
    // ------------------------------------------------------------------
    text_byte_t   byte_queue [$];
    logic [7:0]   msg_bytes [$];
    field_event_t pending_events [$];
    int           stim_count = 0;
    int           n_messages = 0;

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            msg_bytes.push_back(s[k]);
    endtask

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == sdpae_pkg::CH_CR || c == sdpae_pkg::CH_LF);
        return c;
    endfunction

    task automatic add_value();
        int n;
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++)
            msg_bytes.push_back(value_char());
    endtask

    task automatic add_line(input bit with_term);
        int    sel;
        int    n;
        string nm;
        sel = $urandom_range(0, 19);
        if (sel < 4)
        begin
            add_text("c=");
            add_value();
        end
        else if (sel < 11)
        begin
            // Well-formed attribute with optional leading blanks in the value.
            add_text("a=");
            add_text(attr_names[$urandom_range(0, 4)]);
            msg_bytes.push_back(sdpae_pkg::CH_COLON);
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++)
                msg_bytes.push_back($urandom_range(0, 1) ? sdpae_pkg::CH_SPACE
                                                         : sdpae_pkg::CH_TAB);
            add_value();
        end
        else if (sel < 14)
        begin
            // Near-miss names: clipped, extended, overlong, or missing the colon.
            add_text("a=");
            nm = attr_names[$urandom_range(0, 4)];
            case ($urandom_range(0, 3))
                0: add_text(nm.substr(0, nm.len() - 2));
                1:
                begin
                    add_text(nm);
                    msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
                end
                2:
                begin
                    n = $urandom_range(12, 20);
                    for (int k = 0; k < n; k++)
                        msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7a)));
                end
                default: add_text(nm);
            endcase
            if (msg_bytes[$] != sdpae_pkg::CH_COLON && $urandom_range(0, 3) != 0)
                msg_bytes.push_back(sdpae_pkg::CH_COLON);
            add_value();
        end
        else if (sel < 16)
        begin
            msg_bytes.push_back(value_char());
            msg_bytes.push_back($urandom_range(0, 1) ? sdpae_pkg::CH_EQUAL : value_char());
            add_value();
        end
        else if (sel >= 18)
        begin
            // Raw noise, terminators and zero bytes included.
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (with_term)
        begin
            case ($urandom_range(0, 30))
                0:       msg_bytes.push_back(sdpae_pkg::CH_NUL);
                1, 2, 3:
                begin
                    msg_bytes.push_back(sdpae_pkg::CH_CR);
                    msg_bytes.push_back(sdpae_pkg::CH_LF);
                end
                default: msg_bytes.push_back($urandom_range(0, 1) ? sdpae_pkg::CH_CR
                                                                  : sdpae_pkg::CH_LF);
            endcase
        end
    endtask

    // Move the assembled message into the send queue, tagging its final byte.
    task automatic flush_message(input bit drain);
        text_byte_t it;
        bit         gen_stop;
        gen_stop = 1'b0;
        foreach (msg_bytes[i])
        begin
            it.b     = msg_bytes[i];
            it.last  = (i == msg_bytes.size() - 1);
            it.drain = drain && (i == 0);
            byte_queue.push_back(it);
            // Bytes after a zero byte are ignored; leave them out of the count.
            if (!gen_stop)
                stim_count++;
            if (it.b == sdpae_pkg::CH_NUL)
                gen_stop = 1'b1;
        end
        msg_bytes.delete();
        n_messages++;
    endtask

    task automatic add_message(input bit drain);
        int lines;
        lines = $urandom_range(1, 8);
        for (int l = 0; l < lines; l++)
            add_line(l != lines - 1 || $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 14) == 0)
            msg_bytes.push_back(sdpae_pkg::CH_NUL);
        if (msg_bytes.size() == 0)
            msg_bytes.push_back(8'($urandom_range(0, 255)));
        flush_message(drain);
    endtask

    // ------------------------------------------------------------------
    // Driver: present bytes at the falling edge, with random gaps.
    // ------------------------------------------------------------------
    logic       in_fire = 1'b0;
    logic       out_fire = 1'b0;
    logic       in_quiet = 1'b0;
    logic       out_quiet = 1'b0;
    int         send_gap = 0;
    int         sink_stall = 0;

    always @(negedge clk)
    begin : drive_bytes
        text_byte_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else if (!(s_axis_tvalid && !in_fire))
        begin
            // The previous transaction completed, or nothing was offered.
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain && pending_events.size() != 0))
            begin
                it = byte_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.b;
                s_axis_tlast  <= it.last;
                send_gap      <= in_quiet ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 79) == 0)
                    in_quiet <= !in_quiet;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: stall between results for a random number of cycles.
    always @(negedge clk)
    begin : drive_sink
        int n;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (out_fire)
        begin
            n = out_quiet ? 0 : $urandom_range(0, 12);
            m_axis_tready <= (n == 0);
            sink_stall    <= (n == 0) ? 0 : n - 1;
            if ($urandom_range(0, 39) == 0)
                out_quiet <= !out_quiet;
        end
        else if (sink_stall != 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: check results and predict at the rising edge.
    // ------------------------------------------------------------------
    int err_count = 0;
    int n_results = 0;
    int n_value_bytes = 0;
    int n_value_ends = 0;
    int n_msg_ends = 0;
    int bytes_taken = 0;
    logic [5:0] seen_fields = 6'd0;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: result %0d: %s: got %0d, expected %0d",
                     $time, n_results, what, got, want);
    endtask

    always @(posedge clk)
    begin : watch_streams
        field_event_t want;
        field_event_t ev;
        logic         emit;
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_events.size() == 0)
                    report_mismatch("result with nothing expected", m_axis_tdata, 0);
                else
                begin
                    want = pending_events.pop_front();
                    if (m_axis_tuser != want.fid)
                        report_mismatch("field_id", m_axis_tuser, want.fid);
                    if (m_axis_tdata[7:0] != want.vbyte)
                        report_mismatch("value_byte", m_axis_tdata[7:0], want.vbyte);
                    if (m_axis_tdata[8] != want.has_byte)
                        report_mismatch("has_byte", m_axis_tdata[8], want.has_byte);
                    if (m_axis_tdata[9] != want.value_end)
                        report_mismatch("value_end", m_axis_tdata[9], want.value_end);
                    if (m_axis_tlast != want.msg_end)
                        report_mismatch("message_end", m_axis_tlast, want.msg_end);
                    if (m_axis_tdata[15:10] != want.mask)
                        report_mismatch("found_mask", m_axis_tdata[15:10], want.mask);
                    n_value_bytes += want.has_byte;
                    n_value_ends  += want.value_end;
                    n_msg_ends    += want.msg_end;
                    seen_fields   |= want.mask;
                end
                n_results++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_byte(s_axis_tdata, s_axis_tlast, emit, ev);
                if (emit)
                    pending_events.push_back(ev);
                bytes_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed messages, random messages, reset, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        clear_parser();

        // Value closed by the last byte together with a value byte; blanks skipped.
        add_text("c=1\na=aesiv:\t v");
        flush_message(1'b0);
        // Zero byte stops parsing; an all-ones byte then ends the message.
        add_text("x");
        msg_bytes.push_back(sdpae_pkg::CH_NUL);
        msg_bytes.push_back(8'hFF);
        flush_message(1'b0);
        // Empty connection value, then an attribute whose value is cut off at the colon.
        add_text("c=\na=fmtp:");
        flush_message(1'b1);

        while (stim_count < 1000)
            add_message(n_messages % 10 == 4);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the stream to empty and every result to arrive.
        while (byte_queue.size() != 0 || s_axis_tvalid || pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d results", bytes_taken,
                 n_messages, n_results);
        $display("Value bytes %0d, value ends %0d, message ends %0d, fields seen mask %b",
                 n_value_bytes, n_value_ends, n_msg_ends, seen_fields);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #4000000;
        $display("Timeout with %0d bytes unsent and %0d results outstanding",
                 byte_queue.size(), pending_events.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
